@@ rtl/simplified_aes_block_cipher_top_macros.svh @@
// assertion macros used by the port checker
// no dependencies
`ifndef SIMPLIFIED_AES_BLOCK_CIPHER_TOP_MACROS_SVH
`define SIMPLIFIED_AES_BLOCK_CIPHER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SAES_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saes assertion failed");

// next-cycle implication, disabled in reset
`define SAES_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saes assertion failed");

`endif

@@ rtl/saes_pkg.sv @@
// s-aes package: s-boxes, gf(2^4) arithmetic, round functions, key schedule
// no dependencies
package saes_pkg;

    typedef struct packed {
        logic [15:0] rk0;
        logic [15:0] rk1;
        logic [15:0] rk2;
    } round_keys_t;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    localparam logic [7:0] RCON1 = 8'h80;
    localparam logic [7:0] RCON2 = 8'h30;

    localparam logic [3:0] MIX_ENC_A = 4'h1;
    localparam logic [3:0] MIX_ENC_B = 4'h4;
    localparam logic [3:0] MIX_DEC_A = 4'h9;
    localparam logic [3:0] MIX_DEC_B = 4'h2;

    localparam logic [4:0] GF_POLY = 5'h13;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
        4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
    };

    // multiply in gf(2^4) modulo x^4+x+1
    function automatic logic [3:0] gf4_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] acc;
        logic [4:0] x;
        acc = 4'h0;
        x   = {1'b0, a};
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x[3:0];
            end
            x = {x[3:0], 1'b0};
            if (x[4])
            begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] sub_nib(input logic [15:0] v, input logic inv);
        logic [15:0] r;
        r = 16'h0;
        for (int i = 0; i < 4; i++)
        begin
            r[4*i +: 4] = inv ? SBOX_INV[v[4*i +: 4]] : SBOX_FWD[v[4*i +: 4]];
        end
        return r;
    endfunction

    // keep nibbles 0 and 2, swap nibbles 1 and 3
    function automatic logic [15:0] shift_rows(input logic [15:0] v);
        return {v[15:12], v[3:0], v[7:4], v[11:8]};
    endfunction

    // matrix [a b; b a] on each column
    function automatic logic [15:0] mix_cols(input logic [15:0] v, input logic [3:0] a,
                                             input logic [3:0] b);
        logic [3:0] m0;
        logic [3:0] m1;
        logic [3:0] m2;
        logic [3:0] m3;
        m0 = gf4_mul(a, v[15:12]) ^ gf4_mul(b, v[11:8]);
        m1 = gf4_mul(b, v[15:12]) ^ gf4_mul(a, v[11:8]);
        m2 = gf4_mul(a, v[7:4]) ^ gf4_mul(b, v[3:0]);
        m3 = gf4_mul(b, v[7:4]) ^ gf4_mul(a, v[3:0]);
        return {m0, m1, m2, m3};
    endfunction

    function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rcon);
        logic [7:0] rot;
        rot = {w[3:0], w[7:4]};
        return {SBOX_FWD[rot[7:4]], SBOX_FWD[rot[3:0]]} ^ rcon;
    endfunction

    function automatic round_keys_t expand_key(input logic [15:0] key);
        logic [7:0] w2;
        logic [7:0] w3;
        logic [7:0] w4;
        logic [7:0] w5;
        round_keys_t rk;
        w2 = key[15:8] ^ key_g(key[7:0], RCON1);
        w3 = w2 ^ key[7:0];
        w4 = w2 ^ key_g(w3, RCON2);
        w5 = w4 ^ w3;
        rk.rk0 = key;
        rk.rk1 = {w2, w3};
        rk.rk2 = {w4, w5};
        return rk;
    endfunction

endpackage

@@ rtl/saes_key_sched.sv @@
// s-aes key schedule: expands a written key into three registered round keys
// depends on saes_pkg
module saes_key_sched (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [15:0]            cipher_key,
    output saes_pkg::round_keys_t  round_keys
);

    saes_pkg::round_keys_t rk_reg;
    saes_pkg::round_keys_t rk_next;

    always_comb
    begin
        rk_next = rk_reg;
        if (cfg_valid && cfg_ready)
        begin
            rk_next = saes_pkg::expand_key(cipher_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_reg <= saes_pkg::expand_key(16'h0000);
        end
        else
        begin
            rk_reg <= rk_next;
        end
    end

    assign round_keys = rk_reg;

endmodule

@@ rtl/saes_cipher.sv @@
// s-aes two-round cipher pass, encrypt or decrypt, one block per cycle
// depends on saes_pkg
module saes_cipher (
    input  logic                   kind,
    input  logic [15:0]            block_in,
    input  saes_pkg::round_keys_t  round_keys,
    output logic [15:0]            block_out
);

    logic [15:0] enc_r1;
    logic [15:0] enc_r2;
    logic [15:0] enc_out;
    logic [15:0] dec_r1;
    logic [15:0] dec_r2;
    logic [15:0] dec_out;

    // encryption path
    assign enc_r1  = saes_pkg::shift_rows(saes_pkg::sub_nib(block_in ^ round_keys.rk0, 1'b0));
    assign enc_r2  = saes_pkg::mix_cols(enc_r1, saes_pkg::MIX_ENC_A, saes_pkg::MIX_ENC_B)
                     ^ round_keys.rk1;
    assign enc_out = saes_pkg::shift_rows(saes_pkg::sub_nib(enc_r2, 1'b0)) ^ round_keys.rk2;

    // decryption path
    assign dec_r1  = saes_pkg::sub_nib(saes_pkg::shift_rows(block_in ^ round_keys.rk2), 1'b1)
                     ^ round_keys.rk1;
    assign dec_r2  = saes_pkg::mix_cols(dec_r1, saes_pkg::MIX_DEC_A, saes_pkg::MIX_DEC_B);
    assign dec_out = saes_pkg::sub_nib(saes_pkg::shift_rows(dec_r2), 1'b1) ^ round_keys.rk0;

    assign block_out = (kind == saes_pkg::KIND_DECRYPT) ? dec_out : enc_out;

endmodule

@@ rtl/simplified_aes_block_cipher_top.sv @@
// simplified aes (16-bit block, 16-bit key) cipher top level
// depends on saes_pkg, saes_key_sched, saes_cipher
//
// Takes one block per cycle while the output is not stalled: an accepted item
// is captured in an input register, passes one combinational
// two-round cipher (encrypt or decrypt chosen by kind), and lands in the result
// register. With out_ready held high the throughput is one item per cycle; a
// stalled result holds in the result register while one more item waits in the
// input register. Writing cipher_key expands it into the round keys at the
// write edge, so items accepted at that edge or later use the new key.
// cfg_ready is always high. After reset the key is zero.
module simplified_aes_block_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cipher_key,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] block_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] block_out
);

    saes_pkg::round_keys_t round_keys;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_kind_reg;
    logic [15:0] s1_block_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_block_reg;
    logic [15:0] cipher_result;
    logic        s1_advance;
    logic        in_accept;

    assign cfg_ready = 1'b1;

    saes_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cipher_key (cipher_key),
        .round_keys (round_keys)
    );

    saes_cipher u_cipher (
        .kind       (s1_kind_reg),
        .block_in   (s1_block_reg),
        .round_keys (round_keys),
        .block_out  (cipher_result)
    );

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg  <= kind;
            s1_block_reg <= block_in;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_block_reg <= cipher_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign block_out = out_block_reg;

endmodule

@@ rtl/saes_port_checker.sv @@
// port-level assertions for the s-aes top level, bound to it
// depends on simplified_aes_block_cipher_top_macros.svh
`include "simplified_aes_block_cipher_top_macros.svh"

module saes_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] block_out
);

    // stalled result stays
    `SAES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SAES_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(block_out))
    // only a stalled result can back-pressure the input
    `SAES_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_ready, out_valid && !out_ready)
    // an accepted item is followed by out_valid, set through the input and result registers
    `SAES_ASSERT_NEXT(a_accept_result, clk, rst_n, in_valid && in_ready, ##1 out_valid)

endmodule

bind simplified_aes_block_cipher_top saes_port_checker u_saes_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .block_out (block_out)
);
